/* hdl/double_sha256_nonce_check_unit_defines.svh */
// Assertion macros shared by the double SHA-256 nonce check unit.
// Depends on nothing; the asserting module supplies aclk and aresetn.
`ifndef DOUBLE_SHA256_NONCE_CHECK_UNIT_DEFINES_SVH
`define DOUBLE_SHA256_NONCE_CHECK_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DSNC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that, when true, forces another one on the next clock edge.
`define DSNC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/dsnc_pkg.sv */
// Constants, round tables and SHA-256 step functions for the nonce check unit.
// Depends on nothing; used by the hash core and the top level.
package dsnc_pkg;

    localparam int NONCE_W     = 64;
    localparam int DIFF_W      = 6;
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DIG_IDX_W   = 5;
    localparam int DD_STEPS    = 4;
    localparam int DD_STAGES   = NONCE_W / DD_STEPS;
    localparam int FIFO_DEPTH  = 256;
    localparam int FIFO_AW     = 8;
    localparam int CNT_W       = 9;
    localparam int BLOCK_W     = 512;
    localparam int DIGEST_W    = 256;
    localparam int ROUNDS      = 64;
    localparam logic [7:0] NIBBLE_MAX = 8'h0f;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [DIGEST_W-1:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression round; state is a..h from the top word down.
    function automatic logic [DIGEST_W-1:0] sha_round(input logic [DIGEST_W-1:0] st,
                                                      input logic [31:0] w,
                                                      input logic [31:0] k);
        logic [31:0] a, b, c, d, e, f, g, h, s1, ch, t1, s0, mj, t2;
        a  = st[255:224]; b = st[223:192]; c = st[191:160]; d = st[159:128];
        e  = st[127:96];  f = st[95:64];   g = st[63:32];   h = st[31:0];
        s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + k + w;
        s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        mj = (a & b) ^ (a & c) ^ (b & c);
        t2 = s0 + mj;
        return {t1 + t2, a, b, c, d + t1, e, f, g};
    endfunction

    // Slides the 16-word schedule window by one word, oldest word on top.
    function automatic logic [BLOCK_W-1:0] sha_sched(input logic [BLOCK_W-1:0] win);
        logic [31:0] w0, w1, w9, w14, s0, s1;
        w0  = win[511:480];
        w1  = win[479:448];
        w9  = win[223:192];
        w14 = win[63:32];
        s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        return {win[479:0], w0 + s0 + w9 + s1};
    endfunction

endpackage

/* hdl/dsnc_sha_core.sv */
// Fully unrolled single-block SHA-256: one round per register stage.
// Depends on dsnc_pkg; carries an opaque side word along with each item.
module dsnc_sha_core #(
    parameter int SIDE_W = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [dsnc_pkg::BLOCK_W-1:0]   in_block,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [dsnc_pkg::DIGEST_W-1:0]  out_digest,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int R = dsnc_pkg::ROUNDS;

    logic [R:0]                          v_reg;
    logic [dsnc_pkg::DIGEST_W-1:0]       st_reg   [R+1];
    logic [dsnc_pkg::DIGEST_W-1:0]       st_next  [R+1];
    logic [dsnc_pkg::BLOCK_W-1:0]        w_reg    [R+1];
    logic [dsnc_pkg::BLOCK_W-1:0]        w_next   [R+1];
    logic [SIDE_W-1:0]                   sd_reg   [R+1];
    logic [SIDE_W-1:0]                   sd_next  [R+1];
    logic                                dv_reg;
    logic [dsnc_pkg::DIGEST_W-1:0]       dg_reg;
    logic [SIDE_W-1:0]                   ds_reg;
    logic [dsnc_pkg::DIGEST_W-1:0]       dg_next;

    always_comb begin
        st_next[0] = dsnc_pkg::INIT_H;
        w_next[0]  = in_block;
        sd_next[0] = in_side;
        for (int r = 0; r < R; r++) begin
            st_next[r+1] = dsnc_pkg::sha_round(st_reg[r], w_reg[r][511:480],
                                               dsnc_pkg::ROUND_K[r]);
            w_next[r+1]  = dsnc_pkg::sha_sched(w_reg[r]);
            sd_next[r+1] = sd_reg[r];
        end
        for (int i = 0; i < 8; i++) begin
            dg_next[255-32*i -: 32] = st_reg[R][255-32*i -: 32]
                                    + dsnc_pkg::INIT_H[255-32*i -: 32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            dv_reg <= 1'b0;
        end else begin
            v_reg  <= {v_reg[R-1:0], in_valid};
            dv_reg <= v_reg[R];
        end
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r <= R; r++) begin
            st_reg[r] <= st_next[r];
            w_reg[r]  <= w_next[r];
            sd_reg[r] <= sd_next[r];
        end
        dg_reg <= dg_next;
        ds_reg <= sd_reg[R];
    end

    assign out_valid  = dv_reg;
    assign out_digest = dg_reg;
    assign out_side   = ds_reg;

endmodule

/* hdl/double_sha256_nonce_check_unit.sv */
// Top level of the double SHA-256 nonce check unit.
// Depends on dsnc_pkg, dsnc_sha_core and the assertion macro header.
//
// Usage. Each item on the s_ channel carries one 64-bit candidate nonce in
// s_tdata. The unit writes it as decimal text, hashes the text, hashes the
// first digest followed by the text again, and tests the leading zero nibbles
// of the second digest against the difficulty register. Each item yields one
// result item on the m_ channel: the nonce echoed in m_tdata and the hit flag
// in m_tuser. Results leave in the order the items came in.
// The difficulty register is to be written over the cfg_ channel only while
// the unit is idle; the unit does not enforce this. cfg_ready is always high.
// Reset sets difficulty to 1. From input acceptance to m_tvalid there are 16
// binary-to-decimal stages, two text assembly stages, 66 stages per SHA-256
// pass (64 rounds, block load, final add), a check stage and the result queue
// with its output register. Throughput is one item per cycle while s_tready is
// high. Finished results enter a 256-entry queue. A credit count of items in
// flight holds s_tready low only when 256 items are accepted but undelivered,
// so a stalled receiver never stops the hash pipeline and nothing is lost.
// Synchronous active-low reset clears all valid bits, the queue and counters.
`include "double_sha256_nonce_check_unit_defines.svh"

module double_sha256_nonce_check_unit #(
    parameter int MAX_DIGITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: difficulty.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] nonce
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] nonce_out
    output logic [0:0]  m_tuser    // [0] hit
);

    localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
    localparam int TEXT_W = 8 * MAX_DIGITS;
    localparam int SIDE1_W = TEXT_W + LEN_W + dsnc_pkg::NONCE_W;
    localparam int DDS    = dsnc_pkg::DD_STAGES;

    // Configuration.
    logic [dsnc_pkg::DIFF_W-1:0] difficulty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            difficulty_reg <= dsnc_pkg::DIFF_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            difficulty_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    // Credit accounting.
    logic                       s_accept;
    logic                       m_accept;
    logic [dsnc_pkg::CNT_W-1:0] inflight_reg;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = inflight_reg < dsnc_pkg::CNT_W'(dsnc_pkg::FIFO_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + dsnc_pkg::CNT_W'(s_accept)
                                         - dsnc_pkg::CNT_W'(m_accept);
        end
    end

    // Binary to decimal, four double-dabble steps per stage.
    logic [DDS:0]                  dd_v_reg;
    logic [dsnc_pkg::NONCE_W-1:0]  dd_bin_reg   [DDS+1];
    logic [dsnc_pkg::NONCE_W-1:0]  dd_bin_next  [DDS+1];
    logic [dsnc_pkg::BCD_W-1:0]    dd_bcd_reg   [DDS+1];
    logic [dsnc_pkg::BCD_W-1:0]    dd_bcd_next  [DDS+1];
    logic [dsnc_pkg::NONCE_W-1:0]  dd_nonce_reg [DDS+1];
    logic [dsnc_pkg::NONCE_W-1:0]  dd_nonce_next[DDS+1];

    always_comb begin
        logic [dsnc_pkg::NONCE_W-1:0] bin;
        logic [dsnc_pkg::BCD_W-1:0]   bcd;
        dd_bin_next[0]   = s_tdata;
        dd_bcd_next[0]   = '0;
        dd_nonce_next[0] = s_tdata;
        for (int s = 0; s < DDS; s++) begin
            bin = dd_bin_reg[s];
            bcd = dd_bcd_reg[s];
            for (int j = 0; j < dsnc_pkg::DD_STEPS; j++) begin
                for (int d = 0; d < dsnc_pkg::BCD_DIGITS; d++) begin
                    if (bcd[4*d +: 4] >= 4'd5) begin
                        bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                    end
                end
                bcd = {bcd[dsnc_pkg::BCD_W-2:0], bin[dsnc_pkg::NONCE_W-1]};
                bin = {bin[dsnc_pkg::NONCE_W-2:0], 1'b0};
            end
            dd_bin_next[s+1]   = bin;
            dd_bcd_next[s+1]   = bcd;
            dd_nonce_next[s+1] = dd_nonce_reg[s];
        end
    end

    // Length of the kept digits without leading zeros, at least one.
    logic                          ln_v_reg;
    logic [LEN_W-1:0]              ln_len_reg;
    logic [LEN_W-1:0]              ln_len_next;
    logic [dsnc_pkg::BCD_W-1:0]    ln_bcd_reg;
    logic [dsnc_pkg::NONCE_W-1:0]  ln_nonce_reg;

    always_comb begin
        ln_len_next = LEN_W'(1);
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (dd_bcd_reg[DDS][4*d +: 4] != 4'd0) begin
                ln_len_next = LEN_W'(d + 1);
            end
        end
    end

    // Text bytes, most significant digit first; bytes past the length are zero.
    logic                          tx_v_reg;
    logic [TEXT_W-1:0]             tx_text_reg;
    logic [TEXT_W-1:0]             tx_text_next;
    logic [LEN_W-1:0]              tx_len_reg;
    logic [dsnc_pkg::NONCE_W-1:0]  tx_nonce_reg;

    always_comb begin
        logic [dsnc_pkg::DIG_IDX_W-1:0] idx;
        tx_text_next = '0;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            idx = dsnc_pkg::DIG_IDX_W'(int'(ln_len_reg) - 1 - p);
            if (LEN_W'(p) < ln_len_reg) begin
                tx_text_next[8*p +: 8] = {4'h3, ln_bcd_reg[4*idx +: 4]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dd_v_reg <= '0;
            ln_v_reg <= 1'b0;
            tx_v_reg <= 1'b0;
        end else begin
            dd_v_reg <= {dd_v_reg[DDS-1:0], s_accept};
            ln_v_reg <= dd_v_reg[DDS];
            tx_v_reg <= ln_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s <= DDS; s++) begin
            dd_bin_reg[s]   <= dd_bin_next[s];
            dd_bcd_reg[s]   <= dd_bcd_next[s];
            dd_nonce_reg[s] <= dd_nonce_next[s];
        end
        ln_len_reg   <= ln_len_next;
        ln_bcd_reg   <= dd_bcd_reg[DDS];
        ln_nonce_reg <= dd_nonce_reg[DDS];
        tx_text_reg  <= tx_text_next;
        tx_len_reg   <= ln_len_reg;
        tx_nonce_reg <= ln_nonce_reg;
    end

    // First pass: the text alone, padded.
    logic [dsnc_pkg::BLOCK_W-1:0] blk1;

    always_comb begin
        blk1 = '0;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            blk1[511-8*p -: 8] = tx_text_reg[8*p +: 8];
        end
        for (int p = 0; p <= MAX_DIGITS; p++) begin
            if (LEN_W'(p) == tx_len_reg) begin
                blk1[511-8*p -: 8] = 8'h80;
            end
        end
        blk1[7:0] = 8'({tx_len_reg, 3'b000});
    end

    logic                          h1_v;
    logic [dsnc_pkg::DIGEST_W-1:0] h1_digest;
    logic [SIDE1_W-1:0]            h1_side;

    dsnc_sha_core #(.SIDE_W(SIDE1_W)) u_sha1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (tx_v_reg),
        .in_block   (blk1),
        .in_side    ({tx_text_reg, tx_len_reg, tx_nonce_reg}),
        .out_valid  (h1_v),
        .out_digest (h1_digest),
        .out_side   (h1_side)
    );

    // Second pass: first digest, then the same text, padded.
    logic [TEXT_W-1:0]             h1_text;
    logic [LEN_W-1:0]              h1_len;
    logic [dsnc_pkg::NONCE_W-1:0]  h1_nonce;
    logic [8:0]                    blk2_bits;
    logic [dsnc_pkg::BLOCK_W-1:0]  blk2;

    assign {h1_text, h1_len, h1_nonce} = h1_side;
    assign blk2_bits = 9'((32 + int'(h1_len)) * 8);

    always_comb begin
        blk2 = '0;
        blk2[511:256] = h1_digest;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            blk2[255-8*p -: 8] = h1_text[8*p +: 8];
        end
        for (int p = 0; p <= MAX_DIGITS; p++) begin
            if (LEN_W'(p) == h1_len) begin
                blk2[255-8*p -: 8] = 8'h80;
            end
        end
        blk2[15:0] = 16'(blk2_bits);
    end

    logic                          h2_v;
    logic [dsnc_pkg::DIGEST_W-1:0] h2_digest;
    logic [dsnc_pkg::NONCE_W-1:0]  h2_nonce;

    dsnc_sha_core #(.SIDE_W(dsnc_pkg::NONCE_W)) u_sha2 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (h1_v),
        .in_block   (blk2),
        .in_side    (h1_nonce),
        .out_valid  (h2_v),
        .out_digest (h2_digest),
        .out_side   (h2_nonce)
    );

    // Leading-zero rule on the second digest.
    logic [4:0]                    half;
    logic                          zeros_ok;
    logic [7:0]                    sel_byte;
    logic                          hit_next;
    logic                          ck_v_reg;
    logic                          ck_hit_reg;
    logic [dsnc_pkg::NONCE_W-1:0]  ck_nonce_reg;

    assign half = difficulty_reg[5:1];

    always_comb begin
        zeros_ok = 1'b1;
        sel_byte = '0;
        for (int i = 0; i < 32; i++) begin
            if (5'(i) < half && h2_digest[255-8*i -: 8] != 8'd0) begin
                zeros_ok = 1'b0;
            end
            if (5'(i) == half) begin
                sel_byte = h2_digest[255-8*i -: 8];
            end
        end
        if (difficulty_reg[0]) begin
            hit_next = zeros_ok && (sel_byte <= dsnc_pkg::NIBBLE_MAX);
        end else begin
            hit_next = zeros_ok && (sel_byte > dsnc_pkg::NIBBLE_MAX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ck_v_reg <= 1'b0;
        end else begin
            ck_v_reg <= h2_v;
        end
    end

    always_ff @(posedge aclk) begin
        ck_hit_reg   <= hit_next;
        ck_nonce_reg <= h2_nonce;
    end

    // Result queue; the output register is the queue's registered read port.
    logic [dsnc_pkg::NONCE_W:0]   fifo_mem [dsnc_pkg::FIFO_DEPTH];
    logic [dsnc_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [dsnc_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [dsnc_pkg::CNT_W-1:0]   fifo_cnt_reg;
    logic                         pop;
    logic                         m_valid_reg;
    logic [dsnc_pkg::NONCE_W:0]   m_data_reg;

    assign pop = (fifo_cnt_reg != '0) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (ck_v_reg) begin
            fifo_mem[wr_ptr_reg] <= {ck_hit_reg, ck_nonce_reg};
        end
        if (pop) begin
            m_data_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (ck_v_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + dsnc_pkg::CNT_W'(ck_v_reg)
                                         - dsnc_pkg::CNT_W'(pop);
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg[dsnc_pkg::NONCE_W-1:0];
    assign m_tuser  = m_data_reg[dsnc_pkg::NONCE_W];

    `DSNC_ASSERT(a_credit_bound, inflight_reg <= dsnc_pkg::CNT_W'(dsnc_pkg::FIFO_DEPTH), "credit count above queue depth")
    `DSNC_ASSERT(a_queue_covered, fifo_cnt_reg <= inflight_reg, "queue holds more items than are in flight")
    `DSNC_ASSERT_NEXT(a_pop_shows, pop, m_tvalid, "queue read did not present a result")

endmodule
